FILE: sv/pscc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pscc_pkg
// Shared types and constants of the point set congruence check unit.
// ----------------------------------------------------------------------------
package pscc_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 16;
    localparam int CFG_W          = 7;

    // command field codes
    localparam logic CMD_REF  = 1'b0;
    localparam logic CMD_CAND = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RA,
        ST_RA2,
        ST_RB,
        ST_CA,
        ST_CA2,
        ST_CB,
        ST_GADDR,
        ST_GDIFF,
        ST_GMUL,
        ST_GWR,
        ST_TADDR,
        ST_TLATCH,
        ST_SRUN,
        ST_SLAST,
        ST_SCHK,
        ST_NEXT,
        ST_NCHK,
        ST_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic ld_ref_we;
        logic ld_cand_we;
        logic pt_sel_cand;
        logic latch_a;
        logic latch_b;
        logic diff;
        logic mul;
        logic sig_we;
        logic sig_cand;
        logic tgt_latch;
        logic cnt_clr;
        logic cmp_en;
        logic cnt_we;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic count_eq;
    } t_dp_stat;

endpackage : pscc_pkg
`default_nettype wire

FILE: sv/pscc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pscc_dp
// Datapath: point and signature stores, signature arithmetic, match counter.
// ----------------------------------------------------------------------------
module pscc_dp #(
    parameter int MAX_POINTS = pscc_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = pscc_pkg::DEF_COORD_BITS
) (
    input  wire                                  i_clk,
    input  wire  pscc_pkg::t_dp_cmd              i_cmd,
    output pscc_pkg::t_dp_stat                   o_stat,
    input  wire  [$clog2(MAX_POINTS)-1:0]        i_ld_addr,
    input  wire  [$clog2(MAX_POINTS)-1:0]        i_pt_raddr,
    input  wire  [$clog2(MAX_POINTS)-1:0]        i_sig_raddr,
    input  wire  [$clog2(MAX_POINTS)-1:0]        i_sig_waddr,
    input  wire  signed [COORD_BITS-1:0]         i_coord_x,
    input  wire  signed [COORD_BITS-1:0]         i_coord_y
);
    import pscc_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int D_W   = COORD_BITS + 1;
    localparam int SIG_W = 2 * COORD_BITS + 2;
    localparam int PT_W  = 2 * COORD_BITS;

    // point stores, {y, x}
    logic [PT_W-1:0] ref_pt  [MAX_POINTS];
    logic [PT_W-1:0] cand_pt [MAX_POINTS];
    logic [PT_W-1:0] r_ref_pt_rd;
    logic [PT_W-1:0] r_cand_pt_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_ref_we) begin
            ref_pt[i_ld_addr] <= {i_coord_y, i_coord_x};
        end
        r_ref_pt_rd <= ref_pt[i_pt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_cand_we) begin
            cand_pt[i_ld_addr] <= {i_coord_y, i_coord_x};
        end
        r_cand_pt_rd <= cand_pt[i_pt_raddr];
    end

    logic [PT_W-1:0]              pt_rd;
    logic signed [COORD_BITS-1:0] pt_x;
    logic signed [COORD_BITS-1:0] pt_y;

    assign pt_rd = i_cmd.pt_sel_cand ? r_cand_pt_rd : r_ref_pt_rd;
    assign pt_x  = pt_rd[COORD_BITS-1:0];
    assign pt_y  = pt_rd[PT_W-1:COORD_BITS];

    // base point, base vector, offsets, products
    logic signed [COORD_BITS-1:0] r_ax, r_ay;
    logic signed [D_W-1:0]        r_vx, r_vy, r_ux, r_uy;
    logic signed [SIG_W-1:0]      r_p0, r_p1, r_p2, r_p3;
    logic signed [D_W-1:0]        dx, dy;

    assign dx = D_W'(pt_x) - D_W'(r_ax);
    assign dy = D_W'(pt_y) - D_W'(r_ay);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_a) begin
            r_ax <= pt_x;
            r_ay <= pt_y;
        end
        if (i_cmd.latch_b) begin
            r_vx <= dx;
            r_vy <= dy;
        end
        if (i_cmd.diff) begin
            r_ux <= dx;
            r_uy <= dy;
        end
        if (i_cmd.mul) begin
            r_p0 <= r_ux * r_vx;
            r_p1 <= r_uy * r_vy;
            r_p2 <= r_ux * r_vy;
            r_p3 <= r_uy * r_vx;
        end
    end

    // signature stores, {dot, cross}; true values fit SIG_W
    logic [2*SIG_W-1:0] ref_sig  [MAX_POINTS];
    logic [2*SIG_W-1:0] cand_sig [MAX_POINTS];
    logic [2*SIG_W-1:0] r_ref_sig_rd;
    logic [2*SIG_W-1:0] r_cand_sig_rd;
    logic [2*SIG_W-1:0] sig_wdata;
    logic signed [SIG_W-1:0] dot_v, crs_v;

    assign dot_v     = r_p0 + r_p1;
    assign crs_v     = r_p2 - r_p3;
    assign sig_wdata = {dot_v, crs_v};

    always_ff @(posedge i_clk) begin
        if (i_cmd.sig_we && !i_cmd.sig_cand) begin
            ref_sig[i_sig_waddr] <= sig_wdata;
        end
        r_ref_sig_rd <= ref_sig[i_sig_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sig_we && i_cmd.sig_cand) begin
            cand_sig[i_sig_waddr] <= sig_wdata;
        end
        r_cand_sig_rd <= cand_sig[i_sig_raddr];
    end

    // multiplicity of each reference signature within the reference set
    logic [CNT_W-1:0] ref_cnt [MAX_POINTS];
    logic [CNT_W-1:0] r_cnt_rd;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cnt_we) begin
            ref_cnt[i_sig_waddr] <= r_count;
        end
        r_cnt_rd <= ref_cnt[i_sig_raddr];
    end

    // target and match counter
    logic [2*SIG_W-1:0] r_tgt;
    logic [CNT_W-1:0]   r_tgt_cnt;
    logic [2*SIG_W-1:0] stream;

    assign stream = i_cmd.sig_cand ? r_cand_sig_rd : r_ref_sig_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.tgt_latch) begin
            r_tgt     <= r_ref_sig_rd;
            r_tgt_cnt <= r_cnt_rd;
        end
        if (i_cmd.cnt_clr) begin
            r_count <= '0;
        end else if (i_cmd.cmp_en && (stream == r_tgt)) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    assign o_stat.count_eq = (r_count == r_tgt_cnt);

endmodule : pscc_dp
`default_nettype wire

FILE: sv/pscc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pscc_ctrl
// Controller: load counts, check sequencer, result register.
// ----------------------------------------------------------------------------
module pscc_ctrl #(
    parameter int MAX_POINTS = pscc_pkg::DEF_MAX_POINTS
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_we,
    input  wire  [pscc_pkg::CFG_W-1:0]           i_cfg_data,
    input  wire                                  i_in_valid,
    output logic                                 o_in_stall,
    input  wire                                  i_command,
    output logic                                 o_out_valid,
    input  wire                                  i_out_stall,
    output logic                                 o_congruent,
    output pscc_pkg::t_dp_cmd                    o_cmd,
    input  wire  pscc_pkg::t_dp_stat             i_stat,
    output logic [$clog2(MAX_POINTS)-1:0]        o_ld_addr,
    output logic [$clog2(MAX_POINTS)-1:0]        o_pt_raddr,
    output logic [$clog2(MAX_POINTS)-1:0]        o_sig_raddr,
    output logic [$clog2(MAX_POINTS)-1:0]        o_sig_waddr
);
    import pscc_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int EXT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_point_count;
    logic [CNT_W-1:0] r_ref_ld, n_ref_ld, r_cand_ld, n_cand_ld;
    logic [CNT_W-1:0] r_i, n_i, r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k, r_m, n_m;
    logic             r_phase_cand, n_phase_cand;
    logic             r_cmp_pend, n_cmp_pend;
    logic             r_result, n_result;
    logic             r_out_valid, n_out_valid;
    logic             r_out_congruent, n_out_congruent;

    // effective point count
    logic [EXT_W-1:0] cfg_ext;
    logic [EXT_W-1:0] eff_ext;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] n_last;
    logic [IDX_W-1:0] last_idx;

    assign cfg_ext  = EXT_W'(r_point_count);
    assign eff_ext  = (cfg_ext == '0) ? EXT_W'(1) :
                      (cfg_ext > EXT_W'(MAX_POINTS)) ? EXT_W'(MAX_POINTS) : cfg_ext;
    assign n_eff    = eff_ext[CNT_W-1:0];
    assign n_last   = n_eff - CNT_W'(1);
    assign last_idx = n_last[IDX_W-1:0];

    // load bookkeeping
    logic acc, ref_we, cand_we, trigger;
    logic [CNT_W-1:0] ref_nxt, cand_nxt;

    assign acc      = i_in_valid && (r_state == ST_IDLE);
    assign ref_we   = acc && (i_command == CMD_REF) && (r_ref_ld < n_eff);
    assign cand_we  = acc && (i_command == CMD_CAND) && (r_cand_ld < n_eff);
    assign ref_nxt  = ref_we ? r_ref_ld + CNT_W'(1) : r_ref_ld;
    assign cand_nxt = cand_we ? r_cand_ld + CNT_W'(1) : r_cand_ld;
    assign trigger  = acc && (ref_nxt >= n_eff) && (cand_nxt >= n_eff);

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_point_count <= i_cfg_data;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_ref_ld        <= '0;
            r_cand_ld       <= '0;
            r_i             <= '0;
            r_j             <= '0;
            r_k             <= '0;
            r_m             <= '0;
            r_phase_cand    <= 1'b0;
            r_cmp_pend      <= 1'b0;
            r_result        <= 1'b0;
            r_out_valid     <= 1'b0;
            r_out_congruent <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_ref_ld        <= n_ref_ld;
            r_cand_ld       <= n_cand_ld;
            r_i             <= n_i;
            r_j             <= n_j;
            r_k             <= n_k;
            r_m             <= n_m;
            r_phase_cand    <= n_phase_cand;
            r_cmp_pend      <= n_cmp_pend;
            r_result        <= n_result;
            r_out_valid     <= n_out_valid;
            r_out_congruent <= n_out_congruent;
        end
    end

    // next state and commands
    always_comb begin
        n_state         = r_state;
        n_ref_ld        = r_ref_ld;
        n_cand_ld       = r_cand_ld;
        n_i             = r_i;
        n_j             = r_j;
        n_k             = r_k;
        n_m             = r_m;
        n_phase_cand    = r_phase_cand;
        n_cmp_pend      = (r_state == ST_SRUN);
        n_result        = r_result;
        n_out_valid     = r_out_valid && i_out_stall;
        n_out_congruent = r_out_congruent;

        o_cmd             = '0;
        o_cmd.ld_ref_we   = ref_we;
        o_cmd.ld_cand_we  = cand_we;
        o_cmd.pt_sel_cand = r_phase_cand;
        o_cmd.sig_cand    = r_phase_cand;
        o_cmd.cmp_en      = r_cmp_pend;
        o_ld_addr         = (i_command == CMD_REF) ? r_ref_ld[IDX_W-1:0]
                                                   : r_cand_ld[IDX_W-1:0];
        o_pt_raddr        = r_k;
        o_sig_raddr       = r_k;
        o_sig_waddr       = r_k;

        case (r_state)
            ST_IDLE: begin
                n_ref_ld  = ref_nxt;
                n_cand_ld = cand_nxt;
                if (trigger) begin
                    n_ref_ld     = '0;
                    n_cand_ld    = '0;
                    n_phase_cand = 1'b0;
                    if (n_eff == CNT_W'(1)) begin
                        n_result = 1'b1;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_RA;
                    end
                end
            end
            // reference base: P0 and P1
            ST_RA: begin
                o_pt_raddr = '0;
                n_state    = ST_RA2;
            end
            ST_RA2: begin
                o_cmd.latch_a = 1'b1;
                o_pt_raddr    = IDX_W'(1);
                n_state       = ST_RB;
            end
            ST_RB: begin
                o_cmd.latch_b = 1'b1;
                n_k           = '0;
                n_state       = ST_GADDR;
            end
            // candidate base: Pi and Pj
            ST_CA: begin
                o_pt_raddr = r_i[IDX_W-1:0];
                n_state    = ST_CA2;
            end
            ST_CA2: begin
                o_cmd.latch_a = 1'b1;
                o_pt_raddr    = r_j[IDX_W-1:0];
                n_state       = ST_CB;
            end
            ST_CB: begin
                o_cmd.latch_b = 1'b1;
                n_k           = '0;
                n_state       = ST_GADDR;
            end
            // signature generation, one point at a time through address, difference, multiply and write states
            ST_GADDR: begin
                n_state = ST_GDIFF;
            end
            ST_GDIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = ST_GMUL;
            end
            ST_GMUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_GWR;
            end
            ST_GWR: begin
                o_cmd.sig_we = 1'b1;
                if (r_k == last_idx) begin
                    n_k     = '0;
                    n_state = ST_TADDR;
                end else begin
                    n_k     = r_k + IDX_W'(1);
                    n_state = ST_GADDR;
                end
            end
            // count occurrences of reference signature k
            ST_TADDR: begin
                n_state = ST_TLATCH;
            end
            ST_TLATCH: begin
                o_cmd.tgt_latch = 1'b1;
                o_cmd.cnt_clr   = 1'b1;
                n_m             = '0;
                n_state         = ST_SRUN;
            end
            ST_SRUN: begin
                o_sig_raddr = r_m;
                if (r_m == last_idx) begin
                    n_state = ST_SLAST;
                end else begin
                    n_m = r_m + IDX_W'(1);
                end
            end
            ST_SLAST: begin
                n_state = ST_SCHK;
            end
            ST_SCHK: begin
                if (!r_phase_cand) begin
                    o_cmd.cnt_we = 1'b1;
                    if (r_k == last_idx) begin
                        n_k          = '0;
                        n_i          = '0;
                        n_j          = '0;
                        n_phase_cand = 1'b1;
                        n_state      = ST_NEXT;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = ST_TADDR;
                    end
                end else if (!i_stat.count_eq) begin
                    n_state = ST_NEXT;
                end else if (r_k == last_idx) begin
                    n_result = 1'b1;
                    n_state  = ST_DONE;
                end else begin
                    n_k     = r_k + IDX_W'(1);
                    n_state = ST_TADDR;
                end
            end
            // step to next ordered pair (i, j)
            ST_NEXT: begin
                if (r_j == n_last) begin
                    n_j = '0;
                    n_i = r_i + CNT_W'(1);
                end else begin
                    n_j = r_j + CNT_W'(1);
                end
                n_state = ST_NCHK;
            end
            ST_NCHK: begin
                if (r_i == n_eff) begin
                    n_result = 1'b0;
                    n_state  = ST_DONE;
                end else if (r_i == r_j) begin
                    n_state = ST_NEXT;
                end else begin
                    n_state = ST_CA;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out_congruent = r_result;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_congruent = r_out_congruent;

`ifndef SYNTHESIS
    a_ref_ld_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ref_ld <= CNT_W'(MAX_POINTS) && r_cand_ld <= CNT_W'(MAX_POINTS))
        else $error("load count beyond store depth");

    a_trigger_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        trigger |=> (r_state != ST_IDLE) && (r_ref_ld == '0) && (r_cand_ld == '0))
        else $error("full sets did not start a check");

    a_done_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_ref_ld == '0) && (r_cand_ld == '0))
        else $error("load counts not cleared during check");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && out_free) |=> r_out_valid && (r_out_congruent == $past(r_result)))
        else $error("result not presented");
`endif

endmodule : pscc_ctrl
`default_nettype wire

FILE: sv/point_set_congruence_check_unit.sv
// Loading: a point is taken while idle; the word that completes both sets starts a check.
// Check: reference signatures are built and counted first, then ordered candidate pairs are
// tried in turn until one matches, one signature compared per cycle in the scan loop.
// Throughput: one point per cycle while loading; no input is taken while a check runs.
// Reset: synchronous, active low; clears counts and point_count to 1. Stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_set_congruence_check_unit
// Decides whether a candidate point set matches a reference set under rotation
// plus translation.
// ----------------------------------------------------------------------------
module point_set_congruence_check_unit #(
    parameter int MAX_POINTS = pscc_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = pscc_pkg::DEF_COORD_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [pscc_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_command,
    input  wire  signed [COORD_BITS-1:0] i_coord_x,
    input  wire  signed [COORD_BITS-1:0] i_coord_y,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_congruent
);
    import pscc_pkg::*;

    localparam int IDX_W = $clog2(MAX_POINTS);

    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;
    logic [IDX_W-1:0] ld_addr, pt_raddr, sig_raddr, sig_waddr;

    // sequencer
    pscc_ctrl #(
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_congruent (o_congruent),
        .o_cmd       (dp_cmd),
        .i_stat      (dp_stat),
        .o_ld_addr   (ld_addr),
        .o_pt_raddr  (pt_raddr),
        .o_sig_raddr (sig_raddr),
        .o_sig_waddr (sig_waddr)
    );

    // stores and arithmetic
    pscc_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_ld_addr   (ld_addr),
        .i_pt_raddr  (pt_raddr),
        .i_sig_raddr (sig_raddr),
        .i_sig_waddr (sig_waddr),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y)
    );

endmodule : point_set_congruence_check_unit
`default_nettype wire

FILE: sim/point_set_congruence_check_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_set_congruence_check_unit_tb
// Loads reference and candidate point sets through the word handshake and
// checks each congruence answer against a predictor built into a scoreboard
// class. Runs directed corner sets, then random rotated, translated and
// shuffled sets under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------

// Predictor plus queue of expected answers
class congruence_scoreboard;
    int           mismatches;
    bit           answers_due[$];
    bit [6:0]     count_reg;
    int unsigned  ref_cnt, cand_cnt;
    longint       ref_x[64], ref_y[64], cand_x[64], cand_y[64];

    function new();
        mismatches = 0;
        count_reg  = 1;
        ref_cnt    = 0;
        cand_cnt   = 0;
    endfunction

    function int unsigned set_size();
        if (count_reg == 0) return 1;
        if (count_reg > 64) return 64;
        return count_reg;
    endfunction

    // (dot, cross) signatures of set points against base a->b, sorted
    function void signatures(bit use_cand, int a, int b, int n,
                             ref longint d[64], ref longint c[64]);
        longint vx, vy, ux, uy, td, tc;
        int     m;
        for (int k = 0; k < n; k++) begin
            if (use_cand) begin
                vx = cand_x[b] - cand_x[a]; vy = cand_y[b] - cand_y[a];
                ux = cand_x[k] - cand_x[a]; uy = cand_y[k] - cand_y[a];
            end else begin
                vx = ref_x[b] - ref_x[a]; vy = ref_y[b] - ref_y[a];
                ux = ref_x[k] - ref_x[a]; uy = ref_y[k] - ref_y[a];
            end
            d[k] = ux * vx + uy * vy;
            c[k] = ux * vy - uy * vx;
        end
        for (int k = 1; k < n; k++) begin
            td = d[k]; tc = c[k]; m = k;
            while (m > 0 && (td < d[m-1] || (td == d[m-1] && tc < c[m-1]))) begin
                d[m] = d[m-1]; c[m] = c[m-1]; m--;
            end
            d[m] = td; c[m] = tc;
        end
    endfunction

    function bit sets_congruent(int n);
        longint rd[64], rc[64], cd[64], cc[64];
        bit     same;
        if (n <= 1) return 1;
        signatures(0, 0, 1, n, rd, rc);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                if (i == j) continue;
                signatures(1, i, j, n, cd, cc);
                same = 1;
                for (int k = 0; k < n; k++)
                    if (rd[k] != cd[k] || rc[k] != cc[k]) begin
                        same = 0;
                        break;
                    end
                if (same) return 1;
            end
        return 0;
    endfunction

    // accepted input word
    function void note_point(bit cmd, shortint x, shortint y);
        int unsigned n;
        n = set_size();
        if (cmd == pscc_pkg::CMD_REF) begin
            if (ref_cnt < n) begin
                ref_x[ref_cnt] = x; ref_y[ref_cnt] = y; ref_cnt++;
            end
        end else if (cand_cnt < n) begin
            cand_x[cand_cnt] = x; cand_y[cand_cnt] = y; cand_cnt++;
        end
        if (ref_cnt >= n && cand_cnt >= n) begin
            answers_due.push_back(sets_congruent(n));
            ref_cnt  = 0;
            cand_cnt = 0;
        end
    endfunction

    task report(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // accepted result word
    task check_answer(bit got);
        bit exp_bit;
        if (answers_due.size() == 0) begin
            report($sformatf("unexpected result congruent=%0d", got));
        end else begin
            exp_bit = answers_due.pop_front();
            if (got !== exp_bit)
                report($sformatf("congruent got %0d want %0d", got, exp_bit));
        end
    endtask
endclass

module point_set_congruence_check_unit_tb;
    import pscc_pkg::*;

    // quiet-cycle limit, sized for a 64-point check with no match
    localparam int WATCHDOG_LIMIT = 80000000;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [6:0]    i_cfg_data;
    logic          i_in_valid;
    logic          o_in_stall;
    logic          i_command;
    logic [15:0]   i_coord_x;
    logic [15:0]   i_coord_y;
    logic          o_out_valid;
    logic          i_out_stall;
    logic          o_congruent;

    congruence_scoreboard sb;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  holdoff_cycles;
    int  quiet_cycles;
    int  items_sent;
    bit  timed_out;

    point_set_congruence_check_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_congruent (o_congruent)
    );

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // result side: random stall, long hold-offs, checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_answer(o_congruent);
        if (holdoff_cycles > 0) begin
            holdoff_cycles <= holdoff_cycles - 1;
            i_out_stall    <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no word moving either way
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            timed_out = 1;
            $display("point_set_congruence_check_unit test failed");
            $finish;
        end
    end

    // called right after a rising edge; returns right after the accepting edge or after an idle gap that follows it
    task send_point(bit cmd, shortint x, shortint y);
        int gap;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_coord_x  <= x;
        i_coord_y  <= y;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_point(cmd, x, y);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender pause until all answers are in, then let the block settle
    task drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.answers_due.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task write_count(bit [6:0] v);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.count_reg = v;
    endtask

    // one reference set and a moved copy: rotation by quarter turns,
    // translation, shuffle; sometimes a nudged point or a mirrored copy
    task send_set_pair(int n, int span, bit full_range);
        shortint rx[$], ry[$], cx[$], cy[$], qx[$], qy[$];
        int      rot, tx, ty, p, k, ri, ci, flaw;
        int      ax, ay, t;
        tx   = $signed($urandom_range(2000)) - 1000;
        ty   = $signed($urandom_range(2000)) - 1000;
        rot  = $urandom_range(3);
        flaw = $urandom_range(9);
        for (k = 0; k < n; k++) begin
            if (full_range) begin
                rx.push_back(shortint'($urandom)); ry.push_back(shortint'($urandom));
            end else begin
                rx.push_back(shortint'($signed($urandom_range(2 * span)) - span));
                ry.push_back(shortint'($signed($urandom_range(2 * span)) - span));
            end
        end
        for (k = 0; k < n; k++) begin
            if (full_range) begin
                qx.push_back(shortint'($urandom)); qy.push_back(shortint'($urandom));
                continue;
            end
            ax = rx[k]; ay = ry[k];
            repeat (rot) begin
                t = ax; ax = -ay; ay = t;
            end
            if (flaw == 0 && k == n - 1) ax = ax + 1;
            if (flaw == 1) ay = -ay;
            qx.push_back(shortint'(ax + tx)); qy.push_back(shortint'(ay + ty));
        end
        while (qx.size() > 0) begin
            p = $urandom_range(qx.size() - 1);
            cx.push_back(qx[p]); cy.push_back(qy[p]);
            qx.delete(p); qy.delete(p);
        end
        ri = 0; ci = 0;
        while (ri < n || ci < n) begin
            if ($urandom_range(19) == 0)
                send_point(1'($urandom_range(1)), shortint'($urandom),
                           shortint'($urandom));
            else if (ci >= n || (ri < n && $urandom_range(1))) begin
                send_point(CMD_REF, rx[ri], ry[ri]); ri++;
            end else begin
                send_point(CMD_CAND, cx[ci], cy[ci]); ci++;
            end
        end
    endtask

    task random_phase(int target);
        int n, r;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 5)       n = 8;
            else if (r < 12) n = 1;
            else             n = $urandom_range(2, 6);
            if (n != sb.set_size()) write_count(7'(n));
            send_set_pair(n, (r % 3 == 0) ? 30000 : 8, r > 85);
        end
    endtask

    initial begin
        sb             = new();
        timed_out      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_cycles = 0;
        quiet_cycles   = 0;
        items_sent     = 0;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command  = CMD_REF;
        i_coord_x  = '0;
        i_coord_y  = '0;
        i_out_stall = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single point sets after reset, extreme coordinates
        send_point(CMD_REF, 16'sh7fff, -16'sh8000);
        send_point(CMD_CAND, -16'sh8000, 16'sh7fff);
        // count zero acts as one; second reference word lands on a full set
        write_count(0);
        send_point(CMD_REF, 16'sh5555, 16'shaaaa);
        send_point(CMD_REF, 1, 1);
        send_point(CMD_CAND, 16'shaaaa, 16'sh5555);
        // zero base vector on both sides
        write_count(2);
        send_point(CMD_REF, 0, 0);
        send_point(CMD_REF, 0, 0);
        send_point(CMD_CAND, 5, 5);
        send_point(CMD_CAND, 5, 5);
        // longest possible base vector, reversed in the candidate
        send_point(CMD_REF, -16'sh8000, -16'sh8000);
        send_point(CMD_REF, 16'sh7fff, 16'sh7fff);
        send_point(CMD_CAND, 16'sh7fff, 16'sh7fff);
        send_point(CMD_CAND, -16'sh8000, -16'sh8000);
        // scaled copy must fail
        send_point(CMD_CAND, 0, 0);
        send_point(CMD_CAND, 2, 0);
        send_point(CMD_REF, 0, 0);
        send_point(CMD_REF, 1, 0);
        // count lowered while a set is partly loaded
        write_count(4);
        send_point(CMD_REF, 0, 0);
        send_point(CMD_REF, 3, 4);
        send_point(CMD_REF, 9, 9);
        write_count(2);
        send_point(CMD_CAND, 10, 10);
        send_point(CMD_CAND, 14, 7);
        // largest sets: count above the maximum, then the maximum itself
        write_count(127);
        send_set_pair(64, 8, 0);
        write_count(64);
        send_set_pair(64, 30000, 0);
        write_count(3);

        // random sets under each idling pattern
        send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(150);
        send_idle_pct = 55; recv_stall_pct = 0;  random_phase(230);
        send_idle_pct = 0;  recv_stall_pct = 55; random_phase(310);
        send_idle_pct = 34; recv_stall_pct = 34; random_phase(390);

        // receiver holds off while the sender keeps offering sets
        send_idle_pct = 0; recv_stall_pct = 0;
        holdoff_cycles = 600;
        write_count(2);
        repeat (6) send_set_pair(2, 8, 0);
        drain();
        random_phase(470);

        drain();
        if (sb.mismatches == 0 && sb.answers_due.size() == 0)
            $display("point_set_congruence_check_unit test passed");
        else
            $display("point_set_congruence_check_unit test failed");
        $finish;
    end
endmodule
